// ===== rtl/core/omp_pkg.sv =====
`default_nettype none

package omp_pkg;

   localparam int SYM_W       = 8;
   localparam int CMD_W       = 2;
   localparam int CNT_W       = 17;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_PATTERN = 2'd1,
      CMD_TEXT    = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_DEC  = 3'b100
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load_pattern;
      logic load_text;
      logic capture;
      logic decide;
   } dp_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/one_mismatch_pattern_matcher.sv =====
// A text beat goes from the idle state through a compare state to a decide
// state, which loads the output register; no beat is taken meanwhile. Clear
// and pattern beats stay idle. A text beat that reaches its decide cycle while
// a result still waits holds there, and the input stalls, until it is taken.
// Reset is synchronous and active high; it empties the pattern and the text
// counters and drops any pending result. No clearing pass is needed.
`default_nettype none

module one_mismatch_pattern_matcher #(
   parameter int PATTERN_MAX = 64,
   parameter int TEXT_MAX    = 65536
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata fields from bit 0: cmd[1:0], symbol[9:2], zero pad[15:10]
   input  wire logic [omp_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                            req_tlast,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata fields from bit 0: window_full[0], start_position[17:1],
   // is_match[18], match_count[35:19], overflow[36], zero pad[39:37]
   output logic [omp_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready
);

   omp_pkg::dp_cmd_type              dp_cmd;
   logic [omp_pkg::CMD_W-1:0]        req_cmd;
   logic [omp_pkg::SYM_W-1:0]        req_symbol;
   logic                             window_full;
   logic [omp_pkg::CNT_W-1:0]        start_position;
   logic                             is_match;
   logic [omp_pkg::CNT_W-1:0]        match_count;
   logic                             overflow;

   assign req_cmd    = req_tdata[1:0];
   assign req_symbol = req_tdata[9:2];

   // The controller sequences each text beat through a compare cycle, where
   // every cell of the row checks one pattern byte against one window byte,
   // and a decide cycle that tests for at most one mismatch and loads the
   // output register.
   omp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_cmd),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd)
   );

   omp_datapath #(
      .PATTERN_MAX (PATTERN_MAX),
      .TEXT_MAX    (TEXT_MAX)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .req_symbol         (req_symbol),
      .req_last           (req_tlast),
      .rsp_window_full    (window_full),
      .rsp_start_position (start_position),
      .rsp_is_match       (is_match),
      .rsp_match_count    (match_count),
      .rsp_overflow       (overflow),
      .rsp_end_of_text    (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, overflow, match_count, is_match, start_position, window_full};

   // A text beat occupies the compare stage, so the next beat must wait.
   a_text_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_cmd == omp_pkg::CMD_TEXT)) |=> !req_tready)
      else $error("input accepted during compare cycle");

   // A window that is not yet full reports no position and no match.
   a_empty_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !window_full) |-> (start_position == '0) && !is_match)
      else $error("partial window reported a position or a match");

   // A match is always counted.
   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && is_match) |-> (match_count != '0))
      else $error("match reported with zero count");

endmodule

`default_nettype wire

// ===== rtl/core/omp_ctrl.sv =====
`default_nettype none

module omp_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic [omp_pkg::CMD_W-1:0] req_cmd,
   output logic                           req_tready,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output omp_pkg::dp_cmd_type            dp_cmd
);

   omp_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               load;

   assign req_tready = (state_ff == omp_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load       = (state_ff == omp_pkg::ST_DEC) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      dp_cmd              = '0;
      dp_cmd.clear        = accept && (req_cmd == omp_pkg::CMD_CLEAR);
      dp_cmd.load_pattern = accept && (req_cmd == omp_pkg::CMD_PATTERN);
      dp_cmd.load_text    = accept && (req_cmd == omp_pkg::CMD_TEXT);
      dp_cmd.capture      = (state_ff == omp_pkg::ST_CMP);
      dp_cmd.decide       = load;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         omp_pkg::ST_IDLE: begin
            if (dp_cmd.load_text) begin
               state_in = omp_pkg::ST_CMP;
            end
         end
         omp_pkg::ST_CMP: begin
            state_in = omp_pkg::ST_DEC;
         end
         omp_pkg::ST_DEC: begin
            if (load) begin
               state_in = omp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = omp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= omp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/omp_datapath.sv =====
`default_nettype none

module omp_datapath #(
   parameter int PATTERN_MAX = 64,
   parameter int TEXT_MAX    = 65536
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire omp_pkg::dp_cmd_type       dp_cmd,
   input  wire logic [omp_pkg::SYM_W-1:0] req_symbol,
   input  wire logic                      req_last,
   output logic                           rsp_window_full,
   output logic [omp_pkg::CNT_W-1:0]      rsp_start_position,
   output logic                           rsp_is_match,
   output logic [omp_pkg::CNT_W-1:0]      rsp_match_count,
   output logic                           rsp_overflow,
   output logic                           rsp_end_of_text
);

   localparam int PLW = $clog2(PATTERN_MAX + 1);
   localparam int TLW = $clog2(TEXT_MAX + 1);
   localparam int CW  = ((PLW > TLW) ? PLW : TLW) + 1;

   // Pattern row is kept aligned with the text window: entry 0 is the
   // newest pattern byte, so cell j compares two fixed registers.
   logic [omp_pkg::SYM_W-1:0] pat_ff [PATTERN_MAX];
   logic [omp_pkg::SYM_W-1:0] win_ff [PATTERN_MAX];
   logic [PLW-1:0]            plen_ff;
   logic [TLW-1:0]            tlen_ff;
   logic                      ovf_ff;
   logic                      last_ff;
   logic [PATTERN_MAX-1:0]    miss_ff, miss_in;
   logic                      full_ff, full_in;
   logic [CW-1:0]             start_ff, start_in;
   logic [omp_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      match;
   logic                      ovf_in;

   logic                      o_full_ff;
   logic [omp_pkg::CNT_W-1:0] o_start_ff;
   logic                      o_match_ff;
   logic [omp_pkg::CNT_W-1:0] o_cnt_ff;
   logic                      o_ovf_ff;
   logic                      o_last_ff;

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      assign miss_in[j] = (PLW'(j) < plen_ff) && (pat_ff[j] != win_ff[j]);
   end

   assign full_in  = (plen_ff != '0) && (CW'(tlen_ff) >= CW'(plen_ff));
   assign start_in = CW'(tlen_ff) - CW'(plen_ff) + CW'(1);
   assign ovf_in   = (tlen_ff >= TLW'(TEXT_MAX));

   // At most one mismatching cell.
   assign match  = full_ff && ((miss_ff & (miss_ff - PATTERN_MAX'(1))) == '0);
   assign cnt_in = (match && (cnt_ff != omp_pkg::CNT_MAX)) ? cnt_ff + 1'b1 : cnt_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.load_pattern && (plen_ff < PLW'(PATTERN_MAX))) begin
         for (int k = PATTERN_MAX - 1; k > 0; k--) begin
            pat_ff[k] <= pat_ff[k-1];
         end
         pat_ff[0] <= req_symbol;
      end
      if (dp_cmd.load_text) begin
         for (int k = PATTERN_MAX - 1; k > 0; k--) begin
            win_ff[k] <= win_ff[k-1];
         end
         win_ff[0] <= req_symbol;
         ovf_ff    <= ovf_in;
         last_ff   <= req_last;
      end
      if (dp_cmd.capture) begin
         miss_ff  <= miss_in;
         full_ff  <= full_in;
         start_ff <= start_in;
      end
      if (dp_cmd.decide) begin
         o_full_ff  <= full_ff;
         o_start_ff <= full_ff ? omp_pkg::CNT_W'(start_ff) : '0;
         o_match_ff <= match;
         o_cnt_ff   <= cnt_in;
         o_ovf_ff   <= ovf_ff;
         o_last_ff  <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || dp_cmd.clear) begin
         plen_ff <= '0;
         tlen_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (dp_cmd.load_pattern && (plen_ff < PLW'(PATTERN_MAX))) begin
            plen_ff <= plen_ff + 1'b1;
         end
         if (dp_cmd.load_text && !ovf_in) begin
            tlen_ff <= tlen_ff + 1'b1;
         end
         if (dp_cmd.decide) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   // The output register keeps its own copy of the count, so a clear taken
   // while a result waits leaves that result intact.
   assign rsp_window_full    = o_full_ff;
   assign rsp_start_position = o_start_ff;
   assign rsp_is_match       = o_match_ff;
   assign rsp_match_count    = o_cnt_ff;
   assign rsp_overflow       = o_ovf_ff;
   assign rsp_end_of_text    = o_last_ff;

endmodule

`default_nettype wire
